@@ rtl/mfbrf_pkg.sv @@
// Shared types and constants for the monochrome frame buffer rectangle fill block.
package mfbrf_pkg;

  // Command and response field widths
  localparam int unsigned XW      = 9;
  localparam int unsigned YW      = 8;
  localparam int unsigned COLW    = 6;
  localparam int unsigned RBW     = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SUBW    = 3;
  localparam int unsigned PRODW   = YW + RBW;

  localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [RBW-1:0]    ROW_BYTES_RST = 7'd8;

  // Command opcodes
  typedef enum logic {
    OP_FILL = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_BYTE,
    ST_MERGE,
    ST_DONE
  } state_e;

endpackage

@@ rtl/mfbrf_if.sv @@
// Command and response channel interfaces for the rectangle fill block.
interface mfbrf_cmd_if;
  import mfbrf_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [XW-1:0]      left_x;
  logic [YW-1:0]      top_y;
  logic [XW-1:0]      right_x;
  logic [YW-1:0]      bottom_y;
  logic               color;
  logic [YW-1:0]      read_row;
  logic [COLW-1:0]    read_col_byte;

  modport source (
    output valid, op, left_x, top_y, right_x, bottom_y, color, read_row, read_col_byte,
    input  ready
  );
  modport sink (
    input  valid, op, left_x, top_y, right_x, bottom_y, color, read_row, read_col_byte,
    output ready
  );
endinterface

interface mfbrf_rsp_if;
  import mfbrf_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_data;
  logic               bad_request;

  modport source (
    output valid, read_data, bad_request,
    input  ready
  );
  modport sink (
    input  valid, read_data, bad_request,
    output ready
  );
endinterface

@@ rtl/mono_framebuffer_rect_fill.sv @@
// Monochrome frame buffer with rectangle fill and byte read-back, top level.
//
// A 1-bit-per-pixel frame store of MAX_ROW_BYTES * MAX_ROWS bytes, rows packed
// MSB-first, addressed as row * row_bytes + byte column. After reset the block
// runs a clearing pass over all MAX_ROW_BYTES * MAX_ROWS bytes (16384 at the default
// sizes), writing one byte per cycle, and accepts no command until it ends;
// row_bytes writes are taken at any time. Commands are handled one at a time by
// a small sequencer around a single-port byte memory, a row base multiplier and
// address adders. A read passes the setup, read request, read capture and done
// states. A fill sets up the row base, then visits each byte of each row:
// whole bytes are written directly, a partial edge byte is read and merged.
// A rejected command goes straight to done. The response sits in an output
// register, so the next command can be taken while it waits to be transferred.
module mono_framebuffer_rect_fill #(
  parameter int unsigned MAX_ROW_BYTES = 64,
  parameter int unsigned MAX_ROWS      = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      row_bytes_we_i,
  input  logic [mfbrf_pkg::RBW-1:0] row_bytes_i,
  mfbrf_cmd_if.sink                 cmd_i,
  mfbrf_rsp_if.source               rsp_o
);
  import mfbrf_pkg::*;

  localparam int unsigned STORE = MAX_ROW_BYTES * MAX_ROWS;
  localparam int unsigned AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned SW    = AW + RBW;
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE - 1);
  localparam logic [10:0]   ROWS_LIM = 11'(MAX_ROWS);

  // Frame store
  logic [BYTE_W-1:0] store_mem [STORE];
  logic [BYTE_W-1:0] rdata_q;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;

  // Control state
  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [RBW-1:0]   row_bytes_q;
  logic             rsp_valid_q, rsp_valid_d;
  logic [BYTE_W-1:0] rsp_data_q, rsp_data_d;
  logic             rsp_bad_q, rsp_bad_d;

  // Command context
  logic             op_q;
  logic             color_q;
  logic [YW-1:0]    row_q;
  logic [YW-1:0]    y_q, y_d;
  logic [YW-1:0]    bottom_q;
  logic [COLW-1:0]  col_q, col_d;
  logic [COLW-1:0]  lb_q;
  logic [COLW-1:0]  rbyte_q;
  logic [BYTE_W-1:0] lmask_q;
  logic [BYTE_W-1:0] rmask_q;
  logic [AW-1:0]    base_q, base_d;
  logic [BYTE_W-1:0] res_data_q, res_data_d;
  logic             res_bad_q, res_bad_d;

  logic             cmd_xfer;
  logic [RBW-1:0]   eff_rb;
  logic             fill_bad;
  logic             read_bad;
  logic [PRODW-1:0] prod;
  logic [BYTE_W-1:0] byte_mask;
  logic             last_col;
  logic             last_row;

  // Effective row width, clamped to the store's row size
  assign eff_rb = (int'(row_bytes_q) > int'(MAX_ROW_BYTES)) ? RBW'(MAX_ROW_BYTES)
                                                             : row_bytes_q;

  // Command checks against the current layout
  assign fill_bad = (eff_rb == '0)
                 || ({1'b0, cmd_i.right_x} >= {eff_rb, 3'b000})
                 || ({3'b000, cmd_i.bottom_y} >= ROWS_LIM)
                 || (cmd_i.left_x > cmd_i.right_x)
                 || (cmd_i.top_y > cmd_i.bottom_y);
  assign read_bad = ({3'b000, cmd_i.read_row} >= ROWS_LIM)
                 || ({1'b0, cmd_i.read_col_byte} >= eff_rb);

  assign cmd_xfer = cmd_i.valid && cmd_i.ready;

  // Row base multiply, registered into base_q
  assign prod = PRODW'(row_q) * PRODW'(eff_rb);

  // Edge masks for the current byte
  assign byte_mask = ((col_q == lb_q) ? lmask_q : FULL_MASK)
                   & ((col_q == rbyte_q) ? rmask_q : FULL_MASK);
  assign last_col  = (col_q == rbyte_q);
  assign last_row  = (y_q == bottom_q);

  assign cmd_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_data_q;
  assign rsp_o.bad_request = rsp_bad_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    y_d         = y_q;
    col_d       = col_q;
    base_d      = base_q;
    res_data_d  = res_data_q;
    res_bad_d   = res_bad_q;
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;
    rsp_bad_d   = rsp_bad_q;
    mem_we      = 1'b0;
    mem_wdata   = ZERO_BYTE;
    mem_addr    = AW'(SW'(base_q) + SW'(col_q));

    if (rsp_o.valid && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = ZERO_BYTE;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_xfer) begin
          // start position of the new command
          y_d   = cmd_i.top_y;
          col_d = (cmd_i.op == OP_READ) ? cmd_i.read_col_byte : cmd_i.left_x[XW-1:SUBW];
          if ((cmd_i.op == OP_READ) ? read_bad : fill_bad) begin
            res_data_d = ZERO_BYTE;
            res_bad_d  = 1'b1;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        base_d  = AW'(prod);
        state_d = (op_q == OP_READ) ? ST_RD_REQ : ST_BYTE;
      end
      ST_RD_REQ: begin
        state_d = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        res_data_d = rdata_q;
        res_bad_d  = 1'b0;
        state_d    = ST_DONE;
      end
      ST_BYTE, ST_MERGE: begin
        if ((state_q == ST_BYTE) && (byte_mask != FULL_MASK)) begin
          // partial byte: read now, merge next cycle
          state_d = ST_MERGE;
        end else begin
          mem_we = 1'b1;
          if (state_q == ST_BYTE) begin
            mem_wdata = color_q ? FULL_MASK : ZERO_BYTE;
          end else begin
            mem_wdata = color_q ? (rdata_q | byte_mask) : (rdata_q & ~byte_mask);
          end
          // step to next byte, then next row
          state_d = ST_BYTE;
          if (last_col) begin
            if (last_row) begin
              res_data_d = ZERO_BYTE;
              res_bad_d  = 1'b0;
              state_d    = ST_DONE;
            end else begin
              y_d    = y_q + 1'b1;
              base_d = AW'(SW'(base_q) + SW'(eff_rb));
              col_d  = lb_q;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_data_q;
          rsp_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      row_bytes_q <= ROW_BYTES_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      if (row_bytes_we_i) begin
        row_bytes_q <= row_bytes_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    y_q        <= y_d;
    col_q      <= col_d;
    base_q     <= base_d;
    res_data_q <= res_data_d;
    res_bad_q  <= res_bad_d;
    rsp_data_q <= rsp_data_d;
    rsp_bad_q  <= rsp_bad_d;
    if (cmd_xfer) begin
      op_q     <= cmd_i.op;
      color_q  <= cmd_i.color;
      row_q    <= (cmd_i.op == OP_READ) ? cmd_i.read_row : cmd_i.top_y;
      bottom_q <= cmd_i.bottom_y;
      lb_q     <= cmd_i.left_x[XW-1:SUBW];
      rbyte_q  <= cmd_i.right_x[XW-1:SUBW];
      lmask_q  <= FULL_MASK >> cmd_i.left_x[SUBW-1:0];
      rmask_q  <= FULL_MASK << (~cmd_i.right_x[SUBW-1:0]);
    end
  end

  // Single-port frame store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= store_mem[mem_addr];
  end

  // Checks
  a_no_cmd_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_i.ready)
    else $error("command taken during clearing pass");

  a_merge_after_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> ($past(state_q) == ST_BYTE))
    else $error("merge write without a preceding read");

  a_col_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BYTE) |-> ((col_q >= lb_q) && (col_q <= rbyte_q)))
    else $error("fill byte column outside rectangle");

  a_row_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BYTE) |-> (y_q <= bottom_q))
    else $error("fill row beyond rectangle bottom");

  a_done_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (state_d == ST_IDLE)) |=> rsp_o.valid)
    else $error("finished command did not load a response");

endmodule
